>>> rtl/generational_slot_allocator_top_defines.svh
// Assertion macros shared by the generational slot allocator RTL.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define GSA_ASSERT_SAME(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define GSA_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

>>> rtl/gsa_pkg.sv
// Shared constants, codes and controller/datapath types for the slot allocator.
package gsa_pkg;

    // Pool geometry; POOL_SLOTS is a power of two so the ring counters wrap freely
    localparam int POOL_SLOTS = 4096;
    localparam int GEN_BITS   = 32;
    localparam int SLOT_W     = $clog2(POOL_SLOTS);
    localparam int PTR_W      = SLOT_W + 1;

    // Field widths of the stream words
    localparam int FUNC_W    = 2;
    localparam int IDX_W     = 16;
    localparam int TAG_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int RES_IDX_W = 12;
    localparam int RES_GEN_W = 32;
    localparam int LIVE_W    = 13;

    // Input word layout
    localparam int IN_FUNC_LO = 0;
    localparam int IN_IDX_LO  = IN_FUNC_LO + FUNC_W;
    localparam int IN_TAG_LO  = IN_IDX_LO + IDX_W;
    localparam int IN_USED_W  = IN_TAG_LO + TAG_W;
    localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

    // Output word layout
    localparam int OUT_STATUS_LO = 0;
    localparam int OUT_IDX_LO    = OUT_STATUS_LO + STATUS_W;
    localparam int OUT_GEN_LO    = OUT_IDX_LO + RES_IDX_W;
    localparam int OUT_LIVE_LO   = OUT_GEN_LO + RES_GEN_W;
    localparam int OUT_USED_W    = OUT_LIVE_LO + LIVE_W;
    localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_USED_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC    = 2'd0,
        FN_FREE     = 2'd1,
        FN_VALIDATE = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_STALE     = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } t_status;

    // Commands from the controller
    typedef struct packed {
        logic clr_en;    // write one reset entry of both memories
        logic accept;    // take the input word, launch first reads
        logic alloc_rd;  // read slot table at the popped free-list entry
        logic exec;      // commit the update and load the output word
    } t_dp_cmd;

    // Status back to the controller
    typedef struct packed {
        logic             clr_last;  // clearing pass is at its last entry
        logic             in_alloc;  // incoming word asks for an allocate
        logic [PTR_W-1:0] fill;      // entries waiting in the free list
        logic [PTR_W-1:0] live;      // slots currently allocated
    } t_dp_sts;

endpackage

>>> rtl/gsa_ctrl.sv
// Controller state machine: clearing pass, input handshake, step sequencing.
module gsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output gsa_pkg::t_dp_cmd o_cmd,
    input  gsa_pkg::t_dp_sts i_sts
);
    import gsa_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_out_free;

    // Take a word only when idle; the output register may still be full
    assign w_accept   = i_s_tvalid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_m_tready;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    // Decode commands for the datapath
    always_comb begin
        o_cmd          = '0;
        o_cmd.clr_en   = (r_state == S_CLEAR);
        o_cmd.accept   = w_accept;
        o_cmd.alloc_rd = (r_state == S_ALLOC_RD);
        o_cmd.exec     = (r_state == S_EXEC) && w_out_free;
    end

    // Hold state and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_accept) r_state <= i_sts.in_alloc ? S_ALLOC_RD : S_EXEC;
                end
                S_ALLOC_RD: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase

            if (o_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/gsa_datapath.sv
// Datapath: free-list and slot-table memories, ring counters, step logic, output word.
module gsa_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [gsa_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  gsa_pkg::t_dp_cmd                 i_cmd,
    output gsa_pkg::t_dp_sts                 o_sts,
    output logic [gsa_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import gsa_pkg::*;

    localparam logic [IDX_W:0]    IDX_LIMIT  = (IDX_W + 1)'(POOL_SLOTS);
    localparam logic [SLOT_W-1:0] CLR_LAST   = SLOT_W'(POOL_SLOTS - 1);
    localparam logic [PTR_W-1:0]  TAIL_RESET = PTR_W'(POOL_SLOTS);

    // Memories: free list of slot indices, slot table of {allocated, generation}
    logic [SLOT_W-1:0]   fl_mem   [POOL_SLOTS];
    logic [GEN_BITS:0]   slot_mem [POOL_SLOTS];

    logic [SLOT_W-1:0]   r_fl_rdata;
    logic [GEN_BITS:0]   r_slot_rdata;

    // Step context
    t_func               r_func;
    logic [IDX_W-1:0]    r_idx;
    logic [TAG_W-1:0]    r_tag;
    logic [SLOT_W-1:0]   r_slot;

    // Ring counters and live total
    logic [PTR_W-1:0]    r_head;
    logic [PTR_W-1:0]    r_tail;
    logic [PTR_W-1:0]    r_live;
    logic [SLOT_W-1:0]   r_clr_addr;
    logic [PTR_W-1:0]    n_head;
    logic [PTR_W-1:0]    n_tail;
    logic [PTR_W-1:0]    n_live;

    // Output word fields
    t_status             r_status;
    logic [RES_IDX_W-1:0] r_res_idx;
    logic [RES_GEN_W-1:0] r_res_gen;
    logic [LIVE_W-1:0]   r_res_live;

    logic [FUNC_W-1:0]   w_in_func;
    logic [IDX_W-1:0]    w_in_idx;
    logic [TAG_W-1:0]    w_in_tag;

    logic                w_slot_ren;
    logic [SLOT_W-1:0]   w_slot_raddr;
    logic                w_slot_we;
    logic [SLOT_W-1:0]   w_slot_waddr;
    logic [GEN_BITS:0]   w_slot_wdata;
    logic                w_fl_we;
    logic [SLOT_W-1:0]   w_fl_waddr;
    logic [SLOT_W-1:0]   w_fl_wdata;

    logic [GEN_BITS-1:0] w_gen;
    logic                w_alc;
    logic [GEN_BITS-1:0] w_gen_inc;
    logic [PTR_W-1:0]    w_fill;
    logic                w_in_range;
    logic                w_tag_match;
    logic                w_upd_slot;
    logic                w_upd_fl;
    t_status             w_status;
    logic [RES_IDX_W-1:0] w_res_idx;
    logic [RES_GEN_W-1:0] w_res_gen;
    logic [GEN_BITS:0]   w_upd_word;

    // Unpack the input word
    assign w_in_func = i_s_tdata[IN_FUNC_LO +: FUNC_W];
    assign w_in_idx  = i_s_tdata[IN_IDX_LO +: IDX_W];
    assign w_in_tag  = i_s_tdata[IN_TAG_LO +: TAG_W];

    // Slot table read: requested index on accept, popped entry on allocate
    assign w_slot_ren   = i_cmd.accept || i_cmd.alloc_rd;
    assign w_slot_raddr = i_cmd.accept ? w_in_idx[SLOT_W-1:0] : r_fl_rdata;

    // Decode the slot word and the ring state
    assign w_gen       = r_slot_rdata[GEN_BITS-1:0];
    assign w_alc       = r_slot_rdata[GEN_BITS];
    assign w_gen_inc   = w_gen + 1'b1;
    assign w_fill      = r_tail - r_head;
    assign w_in_range  = {1'b0, r_idx} < IDX_LIMIT;
    assign w_tag_match = (TAG_W'(w_gen) == r_tag);

    // Work out the step result and the updates it makes
    always_comb begin
        w_status   = ST_STALE;
        w_res_idx  = '0;
        w_res_gen  = '0;
        w_upd_slot = 1'b0;
        w_upd_fl   = 1'b0;
        w_upd_word = {1'b0, w_gen};
        n_head     = r_head;
        n_tail     = r_tail;
        n_live     = r_live;
        case (r_func)
            FN_ALLOC: begin
                if (w_fill == '0) begin
                    w_status = ST_EXHAUSTED;
                end else begin
                    w_status   = ST_OK;
                    w_res_idx  = RES_IDX_W'(r_slot);
                    w_res_gen  = RES_GEN_W'(w_gen);
                    w_upd_slot = 1'b1;
                    w_upd_word = {1'b1, w_gen};
                    n_head     = r_head + 1'b1;
                    n_live     = r_live + 1'b1;
                end
            end
            FN_FREE: begin
                if (w_in_range && w_alc) begin
                    w_status   = ST_OK;
                    w_res_idx  = RES_IDX_W'(r_slot);
                    w_res_gen  = RES_GEN_W'(w_gen_inc);
                    w_upd_slot = 1'b1;
                    w_upd_fl   = 1'b1;
                    w_upd_word = {1'b0, w_gen_inc};
                    n_tail     = r_tail + 1'b1;
                    n_live     = r_live - 1'b1;
                end else begin
                    w_status = ST_NOT_ALLOC;
                end
            end
            FN_VALIDATE: begin
                if (!(r_idx == '0 && r_tag == '0) && w_in_range && w_tag_match && w_alc) begin
                    w_status  = ST_OK;
                    w_res_idx = RES_IDX_W'(r_slot);
                    w_res_gen = RES_GEN_W'(w_gen);
                end
            end
            default: begin
                w_status = ST_STALE;
            end
        endcase
    end

    // Memory write ports: clearing pass or committed update
    always_comb begin
        w_slot_we    = 1'b0;
        w_slot_waddr = r_slot;
        w_slot_wdata = w_upd_word;
        w_fl_we      = 1'b0;
        w_fl_waddr   = r_tail[SLOT_W-1:0];
        w_fl_wdata   = r_slot;
        if (i_cmd.clr_en) begin
            w_slot_we    = 1'b1;
            w_slot_waddr = r_clr_addr;
            w_slot_wdata = {1'b0, GEN_BITS'(1)};
            w_fl_we      = 1'b1;
            w_fl_waddr   = r_clr_addr;
            w_fl_wdata   = r_clr_addr;
        end else if (i_cmd.exec) begin
            w_slot_we = w_upd_slot;
            w_fl_we   = w_upd_fl;
        end
    end

    // Slot table memory
    always_ff @(posedge i_clk) begin
        if (w_slot_we) slot_mem[w_slot_waddr] <= w_slot_wdata;
        if (w_slot_ren) r_slot_rdata <= slot_mem[w_slot_raddr];
    end

    // Free list memory; read the head entry on accept
    always_ff @(posedge i_clk) begin
        if (w_fl_we) fl_mem[w_fl_waddr] <= w_fl_wdata;
        if (i_cmd.accept) r_fl_rdata <= fl_mem[r_head[SLOT_W-1:0]];
    end

    // Control registers: counters and clear address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= TAIL_RESET;
            r_live     <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clr_en) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.exec) begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_live <= n_live;
            end
        end
    end

    // Payload registers: step context and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= t_func'(w_in_func);
            r_idx  <= w_in_idx;
            r_tag  <= w_in_tag;
            r_slot <= w_in_idx[SLOT_W-1:0];
        end else if (i_cmd.alloc_rd) begin
            r_slot <= r_fl_rdata;
        end
        if (i_cmd.exec) begin
            r_status   <= w_status;
            r_res_idx  <= w_res_idx;
            r_res_gen  <= w_res_gen;
            r_res_live <= LIVE_W'(n_live);
        end
    end

    assign o_m_tdata = {{OUT_PAD_W{1'b0}}, r_res_live, r_res_gen, r_res_idx, r_status};

    always_comb begin
        o_sts          = '0;
        o_sts.clr_last = (r_clr_addr == CLR_LAST);
        o_sts.in_alloc = (w_in_func == FN_ALLOC);
        o_sts.fill     = w_fill;
        o_sts.live     = r_live;
    end

endmodule

>>> rtl/generational_slot_allocator_top.sv
// Generational slot allocator: pool of 4096 slots with generation tags and a FIFO free list.
//
// Input stream (i_s_*): one word per request; func 0 allocates, 1 frees a slot,
// 2 validates a handle (slot index plus generation).
// Output stream (o_m_*): one word per request with status, slot index,
// generation and the number of live slots after the request.
// After reset the block runs a clearing pass over all 4096 entries that sets every
// generation to one, every slot free and the free list to 0..4095 in order;
// o_s_tready stays low during the pass.
// Free and validate go from accept straight to the step that loads their result
// word; allocate passes through an extra slot-table read step first: the
// free-list read and the slot-table read are each one registered memory read,
// and allocate needs the free-list entry before it reads the slot table.
// One request is in flight at a time; o_s_tready is high again in the cycle
// the result word first shows on o_m_tvalid.
// If the receiver stalls, the result holds in the output register; the block
// still takes the next request and finishes it up to the point of loading
// its result, where it waits for the register to drain.
module generational_slot_allocator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // func[1:0], slot_index[17:2], tag_generation[49:18], zero fill to 56 bits
    input  logic [gsa_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // status[1:0], result_index[13:2], result_generation[45:14], live_count[58:46]
    output logic [gsa_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import gsa_pkg::*;

    `include "generational_slot_allocator_top_defines.svh"

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_accept;

    assign w_in_accept = i_s_tvalid && o_s_tready;

    gsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    gsa_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (i_s_tdata),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_m_tdata (o_m_tdata)
    );

    // Every slot is either on the free list or allocated
    `GSA_ASSERT_SAME(a_fill_plus_live, 1'b1, (PTR_W + 1)'(w_sts.fill) + (PTR_W + 1)'(w_sts.live) == (PTR_W + 1)'(POOL_SLOTS), "free list fill plus live count differs from pool size")
    // One request at a time: ready drops right after an accept
    `GSA_ASSERT_NEXT(a_one_in_flight, w_in_accept, !o_s_tready, "request accepted while another is in flight")
    // Exhaustion is only reported with every slot allocated
    `GSA_ASSERT_SAME(a_exhausted_full, o_m_tvalid && o_m_tdata[OUT_STATUS_LO +: STATUS_W] == ST_EXHAUSTED, o_m_tdata[OUT_LIVE_LO +: LIVE_W] == LIVE_W'(POOL_SLOTS), "pool reported exhausted with free slots left")

endmodule
